@@ hw/rtl/yhp_pkg.sv @@
// Package for the YUV to HSV pixel unit: widths, config record, divider cell record,
// register index codes and the shift/clamp helper. No dependencies.
`default_nettype none
package yhp_pkg;

    localparam int SHIFT     = 13;
    localparam int PROD_W    = 25;              // 9 bit signed sample times 16 bit gain
    localparam int SUM_W     = PROD_W + 2;      // three products plus rounding
    localparam int DIV_STEPS = 9;               // quotient bits per divider lane
    localparam int REM_W     = 18;              // 85 * 1785 fits in 18 bits
    localparam int DSH_W     = REM_W - 1;
    localparam int Q_W       = DIV_STEPS;

    typedef enum logic [2:0] {
        REG_LUMA_OFFSET   = 3'd0,
        REG_CHROMA_OFFSET = 3'd1,
        REG_LUMA_GAIN     = 3'd2,
        REG_U_BLUE_GAIN   = 3'd3,
        REG_U_GREEN_GAIN  = 3'd4,
        REG_V_GREEN_GAIN  = 3'd5,
        REG_V_RED_GAIN    = 3'd6
    } reg_index_t;

    typedef struct packed {
        logic        [7:0]  luma_offset;
        logic        [7:0]  chroma_offset;
        logic signed [15:0] luma_gain;
        logic signed [15:0] u_blue_gain;
        logic signed [15:0] u_green_gain;
        logic signed [15:0] v_green_gain;
        logic signed [15:0] v_red_gain;
    } cfg_t;

    // One divider lane: partial remainder, aligned divisor, quotient so far.
    typedef struct packed {
        logic [REM_W-1:0] rem;
        logic [DSH_W-1:0] dsh;
        logic [Q_W-1:0]   quo;
    } div_lane_t;

    typedef struct packed {
        logic      vld;
        div_lane_t hue;
        div_lane_t sat;
        logic [7:0] bright;
    } div_cell_t;

    // floor(x / 2^SHIFT) clamped to 0..255
    function automatic logic [7:0] shift_clamp(input logic signed [SUM_W-1:0] x);
        logic signed [SUM_W-1:0] q;
        q = x >>> SHIFT;
        if (q < 0)
            return 8'd0;
        else if (q > SUM_W'(255))
            return 8'd255;
        else
            return q[7:0];
    endfunction

endpackage
`default_nettype wire

@@ hw/rtl/yhp_cell.sv @@
// One restoring-division cell, two lanes (hue and saturation) plus pass-along data.
// Depends on yhp_pkg.
`default_nettype none
module yhp_cell (
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire logic              en,
    input  wire yhp_pkg::div_cell_t cell_in,
    output yhp_pkg::div_cell_t     cell_out
);
    import yhp_pkg::*;

    div_cell_t cell_reg;
    div_cell_t cell_next;

    function automatic div_lane_t step(input div_lane_t l);
        div_lane_t o;
        logic      b;
        b     = l.rem >= {1'b0, l.dsh};
        o.rem = b ? l.rem - {1'b0, l.dsh} : l.rem;
        o.dsh = l.dsh >> 1;
        o.quo = {l.quo[Q_W-2:0], b};
        return o;
    endfunction

    always_comb begin
        cell_next        = cell_in;
        cell_next.hue    = step(cell_in.hue);
        cell_next.sat    = step(cell_in.sat);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cell_reg.vld <= 1'b0;
        end else if (en) begin
            cell_reg <= cell_next;
        end
    end

    assign cell_out = cell_reg;

endmodule
`default_nettype wire

@@ hw/rtl/yhp_color.sv @@
// Front end: offsets, gain products, RGB clamp, max/range/hue dividend, divider setup.
// Five registered stages. Depends on yhp_pkg.
`default_nettype none
module yhp_color (
    input  wire logic          aclk,
    input  wire logic          aresetn,
    input  wire logic          en,
    input  wire logic          in_vld,
    input  wire logic [7:0]    y_sample,
    input  wire logic [7:0]    u_sample,
    input  wire logic [7:0]    v_sample,
    input  wire yhp_pkg::cfg_t cfg,
    output yhp_pkg::div_cell_t cell_out
);
    import yhp_pkg::*;

    // stage A: offsets removed
    logic              a_vld_reg;
    logic signed [8:0] yo_reg, uo_reg, vo_reg;
    // stage B: products
    logic              b_vld_reg;
    logic signed [PROD_W-1:0] py_reg, pvr_reg, pug_reg, pvg_reg, pub_reg;
    // stage C: clamped colors
    logic              c_vld_reg;
    logic [7:0]        r_reg, g_reg, b_reg;
    // stage D: max, range, dividend
    logic              d_vld_reg;
    logic [7:0]        mx_reg, rng_reg;
    logic [10:0]       dvd_reg;
    // stage E: divider inputs
    div_cell_t         e_reg, e_next;

    logic signed [SUM_W-1:0] sum_r, sum_g, sum_b, rt;
    logic [7:0]  mx, mn, rng;
    logic [11:0] dvd;

    assign rt    = SUM_W'(1) <<< (SHIFT - 1);
    assign sum_r = SUM_W'(py_reg) + SUM_W'(pvr_reg) + rt;
    assign sum_g = SUM_W'(py_reg) + SUM_W'(pug_reg) + SUM_W'(pvg_reg) + rt;
    assign sum_b = SUM_W'(py_reg) + SUM_W'(pub_reg) + rt;

    always_comb begin
        mx = r_reg;
        mn = r_reg;
        if (g_reg > mx) mx = g_reg;
        if (b_reg > mx) mx = b_reg;
        if (g_reg < mn) mn = g_reg;
        if (b_reg < mn) mn = b_reg;
        rng = mx - mn;
        // red wins ties, then green
        priority if (r_reg == mx)
            dvd = 12'(g_reg) - 12'(b_reg) + 12'(rng) * 12'd6;
        else if (g_reg == mx)
            dvd = 12'(b_reg) - 12'(r_reg) + 12'(rng) * 12'd2;
        else
            dvd = 12'(r_reg) - 12'(g_reg) + 12'(rng) * 12'd4;
    end

    always_comb begin
        e_next.vld     = d_vld_reg;
        e_next.bright  = mx_reg;
        e_next.hue.rem = REM_W'(dvd_reg) * REM_W'(85);
        e_next.hue.quo = '0;
        // zero range: numerator is zero, any nonzero divisor gives zero
        e_next.hue.dsh = (rng_reg == 8'd0) ? DSH_W'(1) << (DIV_STEPS - 1)
                                           : DSH_W'(rng_reg) << DIV_STEPS;
        e_next.sat.rem = REM_W'(rng_reg) * REM_W'(255);
        e_next.sat.quo = '0;
        e_next.sat.dsh = (mx_reg == 8'd0) ? DSH_W'(1) << (DIV_STEPS - 1)
                                          : DSH_W'(mx_reg) << (DIV_STEPS - 1);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            a_vld_reg <= 1'b0;
            b_vld_reg <= 1'b0;
            c_vld_reg <= 1'b0;
            d_vld_reg <= 1'b0;
            e_reg.vld <= 1'b0;
        end else if (en) begin
            a_vld_reg <= in_vld;
            yo_reg    <= $signed({1'b0, y_sample}) - $signed({1'b0, cfg.luma_offset});
            uo_reg    <= $signed({1'b0, u_sample}) - $signed({1'b0, cfg.chroma_offset});
            vo_reg    <= $signed({1'b0, v_sample}) - $signed({1'b0, cfg.chroma_offset});

            b_vld_reg <= a_vld_reg;
            py_reg    <= yo_reg * cfg.luma_gain;
            pvr_reg   <= vo_reg * cfg.v_red_gain;
            pug_reg   <= uo_reg * cfg.u_green_gain;
            pvg_reg   <= vo_reg * cfg.v_green_gain;
            pub_reg   <= uo_reg * cfg.u_blue_gain;

            c_vld_reg <= b_vld_reg;
            r_reg     <= shift_clamp(sum_r);
            g_reg     <= shift_clamp(sum_g);
            b_reg     <= shift_clamp(sum_b);

            d_vld_reg <= c_vld_reg;
            mx_reg    <= mx;
            rng_reg   <= rng;
            dvd_reg   <= dvd[10:0];

            e_reg     <= e_next;
        end
    end

    assign cell_out = e_reg;

endmodule
`default_nettype wire

@@ hw/rtl/yuv444_to_hsv_pixel_unit.sv @@
// Top level of the YUV 4:4:4 to HSV pixel unit: config registers, front end, divider chain.
// Depends on yhp_pkg, yhp_color, yhp_cell.
//
//  channel   direction  handshake             payload
//  s_        in         s_valid / s_ready     s_y_sample, s_u_sample, s_v_sample
//  m_        out        m_valid / m_ready     m_hue, m_saturation, m_brightness
//  cfg_      in         cfg_valid / cfg_ready cfg_index, cfg_data
//
// One item per cycle sustained unless stalled (5 front-end stages, 9 divider cells).
// The whole pipeline advances together: it stalls only while the last cell holds an
// item that m_ready has not taken, and s_ready drops in that cycle.
// Reset clears the valid bits and loads the config registers with their defaults.
// cfg_ready is always high; writes to index 7 are ignored.
`default_nettype none
module yuv444_to_hsv_pixel_unit (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_valid,
    output wire logic        s_ready,
    input  wire logic [7:0]  s_y_sample,
    input  wire logic [7:0]  s_u_sample,
    input  wire logic [7:0]  s_v_sample,
    output wire logic        m_valid,
    input  wire logic        m_ready,
    output wire logic [7:0]  m_hue,
    output wire logic [7:0]  m_saturation,
    output wire logic [7:0]  m_brightness,
    input  wire logic        cfg_valid,
    output wire logic        cfg_ready,
    input  wire logic [2:0]  cfg_index,
    input  wire logic [15:0] cfg_data
);
    import yhp_pkg::*;

    cfg_t      cfg_reg;
    logic      en;
    div_cell_t chain [DIV_STEPS+1];

    // global advance: last cell empty or being drained
    assign en        = !chain[DIV_STEPS].vld || m_ready;
    assign s_ready   = en;
    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.luma_offset   <= 8'd16;
            cfg_reg.chroma_offset <= 8'd128;
            cfg_reg.luma_gain     <= 16'sd9535;
            cfg_reg.u_blue_gain   <= 16'sd16531;
            cfg_reg.u_green_gain  <= -16'sd3203;
            cfg_reg.v_green_gain  <= -16'sd6660;
            cfg_reg.v_red_gain    <= 16'sd13074;
        end else if (cfg_valid) begin
            unique case (reg_index_t'(cfg_index))
                REG_LUMA_OFFSET:   cfg_reg.luma_offset   <= cfg_data[7:0];
                REG_CHROMA_OFFSET: cfg_reg.chroma_offset <= cfg_data[7:0];
                REG_LUMA_GAIN:     cfg_reg.luma_gain     <= cfg_data;
                REG_U_BLUE_GAIN:   cfg_reg.u_blue_gain   <= cfg_data;
                REG_U_GREEN_GAIN:  cfg_reg.u_green_gain  <= cfg_data;
                REG_V_GREEN_GAIN:  cfg_reg.v_green_gain  <= cfg_data;
                REG_V_RED_GAIN:    cfg_reg.v_red_gain    <= cfg_data;
                default: ;
            endcase
        end
    end

    yhp_color u_color (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .en       (en),
        .in_vld   (s_valid),
        .y_sample (s_y_sample),
        .u_sample (s_u_sample),
        .v_sample (s_v_sample),
        .cfg      (cfg_reg),
        .cell_out (chain[0])
    );

    // one quotient bit per cell, MSB first
    for (genvar i = 0; i < DIV_STEPS; i++) begin : g_div
        yhp_cell u_cell (
            .aclk     (aclk),
            .aresetn  (aresetn),
            .en       (en),
            .cell_in  (chain[i]),
            .cell_out (chain[i+1])
        );
    end

    assign m_valid      = chain[DIV_STEPS].vld;
    assign m_hue        = chain[DIV_STEPS].hue.quo[7:0];
    assign m_saturation = chain[DIV_STEPS].sat.quo[7:0];
    assign m_brightness = chain[DIV_STEPS].bright;

    // saturation quotient never exceeds 255
    a_sat_fits: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> !chain[DIV_STEPS].sat.quo[Q_W-1])
        else $error("saturation quotient overflow");

    // hue before wrap is at most 85*7/2
    a_hue_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> chain[DIV_STEPS].hue.quo <= Q_W'(297))
        else $error("hue quotient out of bound");

    // black pixel has zero saturation and hue
    a_black: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_brightness == 8'd0) |-> (m_saturation == 8'd0 && m_hue == 8'd0))
        else $error("black pixel with nonzero hue or saturation");

    // final saturation remainder is below its divisor
    a_rem: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> chain[DIV_STEPS].sat.rem < REM_W'(m_brightness == 8'd0 ? 8'd1
                                                         : m_brightness))
        else $error("saturation remainder not reduced");

endmodule
`default_nettype wire
